/* hdl/first_fit_bitmap_slot_allocator_unit_assert.svh */
// Assertion macros shared by the allocator RTL.
// Both expect clk and rst_n in scope.
`ifndef FIRST_FIT_BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba assertion failed");

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba assertion failed");

`endif

/* hdl/ffba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int BYTES_W      = 14;
    localparam int SLOT_FIELD_W = 10;
    localparam int STATUS_W     = 2;

    localparam int SLOT_COUNT_DEF = 1024;

    // must be a power of two
    localparam int SLOT_BYTES = 8;
    localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
    localparam int NUM_W      = BYTES_W + 1 - SLOT_SHIFT;

    // bitmap row is one 64-bit word
    localparam int ROW_W     = 64;
    localparam int ROW_SHIFT = $clog2(ROW_W);

    // slots examined per scan cycle
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_SHIFT = $clog2(CHUNK_W);
    localparam int CHUNKS      = ROW_W / CHUNK_W;
    localparam int CHUNK_IW    = $clog2(CHUNKS);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAST_END  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic                    cmd;
        logic [BYTES_W-1:0]      byte_count;
        logic [SLOT_FIELD_W-1:0] release_start;
    } req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot_start;
        logic [STATUS_W-1:0]     status;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic rd_en;
        logic scan_step;
        logic mark_wr;
        logic clear_wr;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic is_release;
        logic num_zero;
        logic rel_empty;
        logic hit;
        logic chunk_last;
        logic row_last;
        logic mark_last;
    } stat_t;

endpackage

`default_nettype wire

/* hdl/ffba_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ffba_req_if;
    logic            valid;
    logic            ready;
    ffba_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffba_rsp_if;
    logic            valid;
    logic            ready;
    ffba_pkg::rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/first_fit_bitmap_slot_allocator_unit.sv */
// Channel   Dir   Payload                               Transfer when
// req       in    cmd, byte_count, release_start        req.valid && req.ready
// rsp       out   slot_start, status                    rsp.valid && rsp.ready
//
// Reset: a clearing pass writes every 64-bit bitmap row to free, one row per
//   cycle; req.ready stays low until it ends.
// Allocate: a prep step; per bitmap row scanned, one read, then one 8-slot chunk
//   per cycle up to the hit; then one read and one write per bitmap row marked.
// Release: prep, then a read-modify-write per bitmap row touched (single port).
// The result sits in an output register; a new request is taken while it waits,
//   and that request finishes once the register has been drained.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_bitmap_slot_allocator_unit_assert.svh"

module first_fit_bitmap_slot_allocator_unit #(
    parameter int SLOT_COUNT = ffba_pkg::SLOT_COUNT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ffba_req_if.sink    req,
    ffba_rsp_if.source  rsp
);

    ffba_pkg::ctl_t   ctl;
    ffba_pkg::stat_t  stat;
    ffba_pkg::rsp_t   rsp_data;
    logic             req_ready;
    logic             rsp_valid;

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    ffba_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .ctl      (ctl),
        .stat     (stat),
        .rsp_data (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

    `FFBA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `FFBA_ASSERT_SAME(a_fail_slot_zero, rsp.valid && (rsp.data.status != ffba_pkg::ST_OK), rsp.data.slot_start == '0)
    `FFBA_ASSERT_SAME(a_no_write_when_idle, ctl.mark_wr || ctl.clear_wr, !req.ready)

endmodule

`default_nettype wire

/* hdl/ffba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffba_datapath #(
    parameter int SLOT_COUNT = ffba_pkg::SLOT_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ffba_pkg::req_t  req_data,
    input  wire ffba_pkg::ctl_t  ctl,
    output ffba_pkg::stat_t      stat,
    output ffba_pkg::rsp_t       rsp_data
);

    localparam int ROW_W  = ffba_pkg::ROW_W;
    localparam int RS     = ffba_pkg::ROW_SHIFT;
    localparam int CW     = ffba_pkg::CHUNK_W;
    localparam int CS     = ffba_pkg::CHUNK_SHIFT;
    localparam int CIW    = ffba_pkg::CHUNK_IW;
    localparam int NW     = ffba_pkg::NUM_W;
    localparam int BW     = ffba_pkg::BYTES_W;
    localparam int SUM_W  = BW + 1;
    localparam int SFW    = ffba_pkg::SLOT_FIELD_W;
    localparam int STW    = ffba_pkg::STATUS_W;
    localparam int ROWS   = (SLOT_COUNT + ROW_W - 1) / ROW_W;
    localparam int RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = $clog2(SLOT_COUNT + 1);
    localparam int W0     = (IDX_W > NW) ? IDX_W : NW;
    localparam int W      = ((W0 > SFW) ? W0 : SFW) + 1;

    logic [ROW_W-1:0] mem [ROWS];

    logic [RAW-1:0]    row_reg, row_next;
    logic              cmd_reg, cmd_next;
    logic [NW-1:0]     num_reg, num_next;
    logic [SFW-1:0]    first_reg, first_next;
    logic [CIW-1:0]    chunk_reg, chunk_next;
    logic [W-1:0]      run_reg, run_next;
    logic [W-1:0]      start_reg, start_next;
    logic [W-1:0]      lo_reg, lo_next;
    logic [W-1:0]      hi_reg, hi_next;
    logic [W-1:0]      res_slot_reg, res_slot_next;
    logic [STW-1:0]    res_status_reg, res_status_next;
    logic [ROW_W-1:0]  rdata_reg;
    ffba_pkg::rsp_t    out_data_reg, out_data_next;

    logic [SUM_W-1:0]  byte_sum;
    logic [CW-1:0]     cbits;
    logic [W-1:0]      base;
    logic [CW-1:0]     used;
    logic [CW-1:0]     any_used;
    logic [CS-1:0]     last_pos [CW];
    logic [W-1:0]      run_at [CW];
    logic              hit;
    logic [W-1:0]      found;
    logic [W-1:0]      run_out;
    logic [W-1:0]      start_out;
    logic [W-1:0]      first_ext;
    logic [W-1:0]      rel_end;
    logic              rel_past;
    logic [W-1:0]      rel_stop;
    logic [W-1:0]      hi_m1;
    logic [ROW_W-1:0]  mask;
    logic [ROW_W-1:0]  wdata;
    logic              wr_en;

    assign byte_sum  = {1'b0, req_data.byte_count} + SUM_W'(ffba_pkg::SLOT_BYTES - 1);
    assign cbits     = rdata_reg[{chunk_reg, {CS{1'b0}}} +: CW];
    assign base      = W'({row_reg, chunk_reg, {CS{1'b0}}});
    assign first_ext = W'(first_reg);
    assign rel_end   = first_ext + W'(num_reg);
    assign rel_past  = rel_end > W'(SLOT_COUNT);
    assign rel_stop  = rel_past ? W'(SLOT_COUNT) : rel_end;
    assign hi_m1     = hi_reg - W'(1);

    // run tracking for one chunk; slots past the store count as used
    always_comb
    begin
        for (int i = 0; i < CW; i++)
        begin
            used[i] = cbits[i] | ((base + W'(i)) >= W'(SLOT_COUNT));
        end
        for (int i = 0; i < CW; i++)
        begin
            any_used[i] = 1'b0;
            last_pos[i] = '0;
            for (int j = 0; j < CW; j++)
            begin
                if (j <= i && used[j])
                begin
                    any_used[i] = 1'b1;
                    last_pos[i] = CS'(j);
                end
            end
            run_at[i] = any_used[i] ? (W'(i) - W'(last_pos[i]))
                                    : (run_reg + W'(i) + W'(1));
        end
        hit   = 1'b0;
        found = start_reg;
        for (int i = CW - 1; i >= 0; i--)
        begin
            if (run_at[i] >= W'(num_reg))
            begin
                hit   = 1'b1;
                found = any_used[i] ? (base + W'(last_pos[i]) + W'(1)) : start_reg;
            end
        end
        run_out   = run_at[CW-1];
        start_out = any_used[CW-1] ? (base + W'(last_pos[CW-1]) + W'(1)) : start_reg;
    end

    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            mask[b] = (W'({row_reg, RS'(b)}) >= lo_reg) && (W'({row_reg, RS'(b)}) < hi_reg);
        end
        if (ctl.clear_wr)
        begin
            wdata = '0;
        end
        else if (cmd_reg == ffba_pkg::CMD_ALLOC)
        begin
            wdata = rdata_reg | mask;
        end
        else
        begin
            wdata = rdata_reg & ~mask;
        end
    end

    assign wr_en = ctl.mark_wr | ctl.clear_wr;

    always_comb
    begin
        stat.is_release = (cmd_reg == ffba_pkg::CMD_RELEASE);
        stat.num_zero   = (num_reg == '0);
        stat.rel_empty  = (first_ext >= rel_stop);
        stat.hit        = hit;
        stat.chunk_last = (chunk_reg == CIW'(ffba_pkg::CHUNKS - 1));
        stat.row_last   = (row_reg == RAW'(ROWS - 1));
        stat.mark_last  = (row_reg == hi_m1[RS +: RAW]);
    end

    always_comb
    begin
        row_next        = row_reg;
        cmd_next        = cmd_reg;
        num_next        = num_reg;
        first_next      = first_reg;
        chunk_next      = chunk_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;

        if (ctl.accept)
        begin
            cmd_next   = req_data.cmd;
            num_next   = byte_sum[SUM_W-1:ffba_pkg::SLOT_SHIFT];
            first_next = req_data.release_start;
        end

        if (ctl.prep)
        begin
            res_slot_next = '0;
            run_next      = '0;
            start_next    = '0;
            chunk_next    = '0;
            if (cmd_reg == ffba_pkg::CMD_RELEASE)
            begin
                lo_next         = first_ext;
                hi_next         = rel_stop;
                row_next        = first_ext[RS +: RAW];
                res_status_next = rel_past ? ffba_pkg::ST_PAST_END : ffba_pkg::ST_OK;
            end
            else
            begin
                row_next        = '0;
                res_status_next = ffba_pkg::ST_OK;
            end
        end

        if (ctl.scan_step)
        begin
            if (hit)
            begin
                lo_next       = found;
                hi_next       = found + W'(num_reg);
                res_slot_next = found;
                row_next      = found[RS +: RAW];
            end
            else
            begin
                run_next   = run_out;
                start_next = start_out;
                if (stat.chunk_last)
                begin
                    chunk_next = '0;
                    if (stat.row_last)
                    begin
                        res_status_next = ffba_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        row_next = row_reg + RAW'(1);
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + CIW'(1);
                end
            end
        end

        if (wr_en)
        begin
            row_next = row_reg + RAW'(1);
        end

        if (ctl.out_load)
        begin
            out_data_next.slot_start = SFW'(res_slot_reg);
            out_data_next.status     = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        num_reg        <= num_next;
        first_reg      <= first_next;
        chunk_reg      <= chunk_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[row_reg];
        end
        if (wr_en)
        begin
            mem[row_reg] <= wdata;
        end
    end

    assign rsp_data = out_data_reg;

endmodule

`default_nettype wire

/* hdl/ffba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    input  wire ffba_pkg::stat_t  stat,
    output ffba_pkg::ctl_t        ctl
);

    ffba_pkg::state_t state_reg, state_next;
    logic             rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;

        case (state_reg)
            ffba_pkg::S_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (stat.row_last)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = ffba_pkg::S_PREP;
                end
            end
            ffba_pkg::S_PREP:
            begin
                ctl.prep = 1'b1;
                if (stat.is_release)
                begin
                    state_next = stat.rel_empty ? ffba_pkg::S_RESULT : ffba_pkg::S_MARK_RD;
                end
                else
                begin
                    state_next = stat.num_zero ? ffba_pkg::S_RESULT : ffba_pkg::S_SCAN_RD;
                end
            end
            ffba_pkg::S_SCAN_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = ffba_pkg::S_SCAN;
            end
            ffba_pkg::S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = ffba_pkg::S_MARK_RD;
                end
                else if (stat.chunk_last)
                begin
                    state_next = stat.row_last ? ffba_pkg::S_RESULT : ffba_pkg::S_SCAN_RD;
                end
            end
            ffba_pkg::S_MARK_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = ffba_pkg::S_MARK_WR;
            end
            ffba_pkg::S_MARK_WR:
            begin
                ctl.mark_wr = 1'b1;
                state_next  = stat.mark_last ? ffba_pkg::S_RESULT : ffba_pkg::S_MARK_RD;
            end
            ffba_pkg::S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ffba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

/* tb/tb_first_fit_bitmap_slot_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_first_fit_bitmap_slot_allocator_unit;

    localparam int NSLOTS      = ffba_pkg::SLOT_COUNT_DEF;
    localparam int SBYTES      = ffba_pkg::SLOT_BYTES;
    localparam int MAX_BYTES   = NSLOTS * SBYTES;
    localparam int RANDOM_REQS = 1100;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 250;

    typedef struct {
        ffba_pkg::req_t r;
        bit             hold;
    } req_item_t;

    typedef struct {
        int start;
        int bytes;
    } run_t;

    logic clk;
    logic rst_n;

    ffba_req_if req_bus();
    ffba_rsp_if rsp_bus();

    first_fit_bitmap_slot_allocator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    req_item_t         pending_req[$];
    ffba_pkg::rsp_t    expected_rsp[$];
    run_t              live_runs[$];
    logic [NSLOTS-1:0] alloc_map;
    logic [NSLOTS-1:0] plan_map;

    int  err_count;
    int  n_alloc;
    int  n_release;
    int  n_exhausted;
    int  n_past_end;
    int  idle_cycles;
    int  send_gap;
    int  send_calm;
    int  take_gap;
    int  take_calm;
    bit  send_valid;
    bit  take_ready;
    ffba_pkg::rsp_t predicted;
    ffba_pkg::rsp_t want;

    // first-fit allocate / release on a slot bitmap
    function automatic ffba_pkg::rsp_t run_request(inout logic [NSLOTS-1:0] map,
                                                   input ffba_pkg::req_t r);
        int unsigned num;
        int unsigned first;
        int unsigned stop;
        int unsigned run_left;
        int unsigned run_start;
        int unsigned x;
        ffba_pkg::rsp_t res;
        num = (int'(r.byte_count) + SBYTES - 1) / SBYTES;
        res = '0;
        res.status = ffba_pkg::ST_OK;
        if (r.cmd == ffba_pkg::CMD_RELEASE) begin
            first = r.release_start;
            stop = (first + num > NSLOTS) ? NSLOTS : first + num;
            for (x = first; x < stop; x++)
                map[x] = 1'b0;
            if (first + num > NSLOTS)
                res.status = ffba_pkg::ST_PAST_END;
        end else begin
            run_left = num;
            run_start = 0;
            for (x = 0; x < NSLOTS && run_left != 0; x++) begin
                if (map[x]) begin
                    run_left = num;
                    run_start = x + 1;
                end else begin
                    run_left--;
                end
            end
            if (run_left != 0) begin
                res.status = ffba_pkg::ST_EXHAUSTED;
            end else begin
                for (x = run_start; x < run_start + num; x++)
                    map[x] = 1'b1;
                res.slot_start = ffba_pkg::SLOT_FIELD_W'(run_start);
            end
        end
        return res;
    endfunction

    function automatic int idle_draw(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = 40;
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic int alloc_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return 0;
        if (pick < 60)
            return $urandom_range(1, 128);
        if (pick < 85)
            return $urandom_range(129, 1024);
        if (pick < 97)
            return $urandom_range(1025, 4096);
        return $urandom_range(4097, MAX_BYTES);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    task automatic push_item(input logic cmd, input int bytes, input int start, input bit hold);
        req_item_t      it;
        ffba_pkg::rsp_t res;
        run_t           run;
        it.r.cmd           = cmd;
        it.r.byte_count    = ffba_pkg::BYTES_W'(bytes);
        it.r.release_start = ffba_pkg::SLOT_FIELD_W'(start);
        it.hold            = hold;
        pending_req.push_back(it);
        res = run_request(plan_map, it.r);
        if (cmd == ffba_pkg::CMD_ALLOC && res.status == ffba_pkg::ST_OK && bytes > 0) begin
            run.start = res.slot_start;
            run.bytes = bytes;
            live_runs.push_back(run);
        end
    endtask

    task automatic clear_all(input bit hold);
        push_item(ffba_pkg::CMD_RELEASE, MAX_BYTES, 0, hold);
        live_runs.delete();
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // stimulus, end of run
    initial begin
        int   i;
        int   k;
        int   pick;
        int   slots;
        int   off;
        bit   hold;
        run_t run;

        rst_n <= 1'b0;
        alloc_map = '0;
        plan_map  = '0;

        // directed
        push_item(ffba_pkg::CMD_ALLOC, 0, 0, 0);
        push_item(ffba_pkg::CMD_ALLOC, 1, 1023, 0);
        push_item(ffba_pkg::CMD_ALLOC, 8, 0, 0);
        push_item(ffba_pkg::CMD_ALLOC, 9, 0, 0);
        push_item(ffba_pkg::CMD_RELEASE, 8, 1, 0);
        push_item(ffba_pkg::CMD_ALLOC, 8, 0, 0);
        push_item(ffba_pkg::CMD_ALLOC, 16, 0, 0);
        push_item(ffba_pkg::CMD_RELEASE, 0, 5, 0);
        push_item(ffba_pkg::CMD_RELEASE, 8, 1023, 0);
        push_item(ffba_pkg::CMD_RELEASE, 16, 1023, 0);
        push_item(ffba_pkg::CMD_RELEASE, MAX_BYTES, 1020, 0);
        push_item(ffba_pkg::CMD_ALLOC, MAX_BYTES, 0, 0);
        clear_all(0);
        push_item(ffba_pkg::CMD_ALLOC, MAX_BYTES, 0, 0);
        push_item(ffba_pkg::CMD_ALLOC, 1, 0, 0);
        push_item(ffba_pkg::CMD_ALLOC, 0, 0, 0);
        push_item(ffba_pkg::CMD_RELEASE, 1, 1023, 0);
        push_item(ffba_pkg::CMD_ALLOC, 8, 0, 0);
        push_item(ffba_pkg::CMD_RELEASE, 40, 512, 0);
        push_item(ffba_pkg::CMD_ALLOC, 33, 0, 0);
        clear_all(1);
        push_item(ffba_pkg::CMD_ALLOC, MAX_BYTES - 7, 0, 0);
        push_item(ffba_pkg::CMD_RELEASE, MAX_BYTES, 1023, 0);
        clear_all(0);

        // random: mostly allocations paired with releases of live runs
        for (i = 0; i < RANDOM_REQS; i++) begin
            hold = (i % 250 == 125);
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                clear_all(hold);
            end else if (pick < 45) begin
                push_item(ffba_pkg::CMD_ALLOC, alloc_size(), $urandom_range(0, NSLOTS - 1),
                          hold);
            end else if (pick < 80 && live_runs.size() != 0) begin
                k = $urandom_range(0, live_runs.size() - 1);
                run = live_runs[k];
                live_runs.delete(k);
                if ($urandom_range(0, 4) == 0) begin
                    slots = (run.bytes + SBYTES - 1) / SBYTES;
                    off = $urandom_range(0, slots - 1);
                    push_item(ffba_pkg::CMD_RELEASE,
                              $urandom_range(1, (slots - off) * SBYTES),
                              run.start + off, hold);
                end else begin
                    push_item(ffba_pkg::CMD_RELEASE, run.bytes, run.start, hold);
                end
            end else if (pick < 92) begin
                push_item(ffba_pkg::CMD_RELEASE, $urandom_range(0, MAX_BYTES),
                          $urandom_range(0, NSLOTS - 1), hold);
            end else begin
                push_item(ffba_pkg::CMD_ALLOC, $urandom_range(0, MAX_BYTES),
                          $urandom_range(0, NSLOTS - 1), hold);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_req.size() != 0 || req_bus.valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d allocations and %0d releases: %0d exhausted, %0d past end",
                 n_alloc, n_release, n_exhausted, n_past_end);
        if (err_count == 0)
            $display("tb_first_fit_bitmap_slot_allocator_unit: PASS");
        else
            $display("tb_first_fit_bitmap_slot_allocator_unit: FAIL");
        $finish;
    end

    // request driver; prediction at transfer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
            req_bus.data  <= '0;
            send_gap = 0;
        end else begin
            send_valid = req_bus.valid;
            if (req_bus.valid && req_bus.ready) begin
                predicted = run_request(alloc_map, req_bus.data);
                expected_rsp.push_back(predicted);
                if (req_bus.data.cmd == ffba_pkg::CMD_RELEASE)
                    n_release++;
                else
                    n_alloc++;
                if (predicted.status == ffba_pkg::ST_EXHAUSTED)
                    n_exhausted++;
                if (predicted.status == ffba_pkg::ST_PAST_END)
                    n_past_end++;
                send_valid = 1'b0;
                send_gap = idle_draw(send_calm);
            end
            if (!send_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_req.size() != 0 &&
                             (!pending_req[0].hold || expected_rsp.size() == 0)) begin
                    req_bus.data <= pending_req[0].r;
                    void'(pending_req.pop_front());
                    send_valid = 1'b1;
                end
            end
            req_bus.valid <= send_valid;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            take_gap = 0;
        end else begin
            take_ready = rsp_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch($sformatf("unexpected result slot_start=%0d status=%0d",
                                              rsp_bus.data.slot_start, rsp_bus.data.status));
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_bus.data.slot_start !== want.slot_start)
                        report_mismatch($sformatf("slot_start %0d, expected %0d",
                                                  rsp_bus.data.slot_start, want.slot_start));
                    if (rsp_bus.data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_bus.data.status, want.status));
                end
                take_gap = idle_draw(take_calm);
                take_ready = (take_gap == 0);
            end else if (!rsp_bus.ready) begin
                if (take_gap > 0)
                    take_gap--;
                take_ready = (take_gap == 0);
            end
            rsp_bus.ready <= take_ready;
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d results still expected", expected_rsp.size());
                $display("tb_first_fit_bitmap_slot_allocator_unit: FAIL");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

endmodule

/* files.f */
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_if.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_bitmap_slot_allocator_unit.sv
tb/tb_first_fit_bitmap_slot_allocator_unit.sv
